FILE: src/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants and font lookup for the glyph to rectangle renderer.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int MaxScale   = 16;
  localparam int CoordW     = 8;
  localparam int ScaleW     = 5;
  localparam int ColorW     = 16;
  localparam int CodeW      = 8;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 16;
  localparam int GlyphCols  = 5;
  localparam int GlyphRows  = 7;
  localparam int DotN       = GlyphCols * GlyphRows;
  localparam int DotIdxW    = $clog2(DotN);
  localparam int ColW       = $clog2(GlyphCols);
  localparam int RowW       = $clog2(GlyphRows);
  localparam int GlyphIdxW  = 4;
  localparam int Advance    = 6;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [GlyphIdxW-1:0] GLYPH_BLANK = 4'd10;
  localparam logic [GlyphIdxW-1:0] GLYPH_DOT   = 4'd11;
  localparam logic [GlyphIdxW-1:0] GLYPH_VEE   = 4'd12;

  localparam logic [CodeW-1:0] CODE_ZERO = 8'h30;
  localparam logic [CodeW-1:0] CODE_NINE = 8'h39;
  localparam logic [CodeW-1:0] CODE_DOT  = 8'h2E;
  localparam logic [CodeW-1:0] CODE_VEE  = 8'h56;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GLYPH_SCALE = 4'd0,
    CFG_DRAW_COLOR  = 4'd1
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [GlyphIdxW-1:0] glyph;
    logic [CoordW-1:0]    pen_x;
    logic [CoordW-1:0]    pen_y;
    logic [ScaleW-1:0]    scale;
    logic [ColorW-1:0]    color;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [GlyphIdxW-1:0] glyph_select(input logic [CodeW-1:0] code);
    logic [GlyphIdxW-1:0] g;
    if (code inside {[CODE_ZERO:CODE_NINE]}) begin
      g = code[GlyphIdxW-1:0];
    end else if (code == CODE_DOT) begin
      g = GLYPH_DOT;
    end else if (code == CODE_VEE) begin
      g = GLYPH_VEE;
    end else begin
      g = GLYPH_BLANK;
    end
    return g;
  endfunction

  // columns packed high to low: column 4 in the top seven bits, row 0 is lsb
  function automatic logic [DotN-1:0] font_bits(input logic [GlyphIdxW-1:0] g);
    logic [DotN-1:0] b;
    case (g)
      4'd0:      b = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      4'd1:      b = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
      4'd2:      b = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
      4'd3:      b = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
      4'd4:      b = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
      4'd5:      b = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
      4'd6:      b = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      4'd7:      b = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
      4'd8:      b = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      4'd9:      b = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      GLYPH_DOT: b = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
      GLYPH_VEE: b = {7'h77, 7'h08, 7'h08, 7'h08, 7'h77};
      default:   b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [ScaleW-1:0] effective_scale(input logic [ScaleW-1:0] s);
    logic [ScaleW-1:0] e;
    if (s == '0) begin
      e = ScaleW'(1);
    end else if (s > ScaleW'(MaxScale)) begin
      e = ScaleW'(MaxScale);
    end else begin
      e = s;
    end
    return e;
  endfunction

  function automatic logic [ColW-1:0] dot_col(input logic [DotIdxW-1:0] idx);
    logic [ColW-1:0] c;
    if (idx >= DotIdxW'(4 * GlyphRows)) begin
      c = ColW'(4);
    end else if (idx >= DotIdxW'(3 * GlyphRows)) begin
      c = ColW'(3);
    end else if (idx >= DotIdxW'(2 * GlyphRows)) begin
      c = ColW'(2);
    end else if (idx >= DotIdxW'(GlyphRows)) begin
      c = ColW'(1);
    end else begin
      c = ColW'(0);
    end
    return c;
  endfunction

  function automatic logic [RowW-1:0] dot_row(input logic [DotIdxW-1:0] idx);
    logic [DotIdxW-1:0] r;
    r = idx - DotIdxW'(dot_col(idx)) * DotIdxW'(GlyphRows);
    return r[RowW-1:0];
  endfunction

endpackage

FILE: src/gtr_if.sv
// ----------------------------------------------------------------------------
// gtr channel interfaces
// Character input, rectangle output and register write channels.
// ----------------------------------------------------------------------------
interface gtr_in_if;
  logic                         valid;
  logic                         ready;
  logic [gtr_pkg::CodeW-1:0]    char_code;
  logic                         restart;
  logic [gtr_pkg::CoordW-1:0]   start_x;
  logic [gtr_pkg::CoordW-1:0]   start_y;

  modport source (output valid, char_code, restart, start_x, start_y, input ready);
  modport sink   (input valid, char_code, restart, start_x, start_y, output ready);
endinterface

interface gtr_out_if;
  logic                         valid;
  logic                         ready;
  logic [gtr_pkg::CoordW-1:0]   rect_x;
  logic [gtr_pkg::CoordW-1:0]   rect_y;
  logic [gtr_pkg::ScaleW-1:0]   rect_side;
  logic [gtr_pkg::ColorW-1:0]   rect_color;
  logic                         empty_res;
  logic                         last;

  modport source (output valid, rect_x, rect_y, rect_side, rect_color, empty_res, last,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_side, rect_color, empty_res, last,
                  output ready);
endinterface

interface gtr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gtr_pkg::CfgIdxW-1:0]   index;
  logic [gtr_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/glyph_to_rectangle_renderer_core.sv
// ----------------------------------------------------------------------------
// glyph_to_rectangle_renderer_core
// Turns characters into filled squares, one per lit dot of a 5x7 font glyph.
// ----------------------------------------------------------------------------
// chr carries one character per beat, with an optional pen restart. rect
// returns one beat per lit dot: corner, side, colour, and last on the final
// beat of the character; a blank glyph gives a single empty_res beat. cfg
// writes glyph_scale (index 0) and draw_color (index 1), always ready.
// the character passes through the job queue, the back end's job register and
// the output register before its first rectangle appears on rect. the back
// end loads a glyph, then emits one rectangle per cycle while rect is not
// stalled (a single beat for a blank); it pops the next job only once idle again.
// the front end takes a character whenever the two-entry job queue has room,
// so up to two characters wait while a glyph is being drawn.
// reset: registers return to scale 1 and colour 0xFFFF, pen to (0, 0), queue
// and output are emptied. a stall on rect holds the output register and the
// back end; the queue then fills and chr.ready drops.
// ----------------------------------------------------------------------------
module glyph_to_rectangle_renderer_core (
  input  logic       clk,
  input  logic       rst,
  gtr_in_if.sink     chr,
  gtr_cfg_if.sink    cfg,
  gtr_out_if.source  rect
);

  logic                   push;
  logic                   pop;
  gtr_pkg::job_t          push_job;
  gtr_pkg::job_t          pop_job;
  gtr_pkg::queue_status_t q_status;

  gtr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .chr      (chr),
    .cfg      (cfg),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  gtr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  gtr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .rect     (rect)
  );

endmodule

FILE: src/gtr_front.sv
// ----------------------------------------------------------------------------
// gtr_front
// Accepts characters, picks the glyph, tracks the pen and holds the registers.
// ----------------------------------------------------------------------------
module gtr_front (
  input  logic                  clk,
  input  logic                  rst,
  gtr_in_if.sink                chr,
  gtr_cfg_if.sink               cfg,
  input  gtr_pkg::queue_status_t q_status,
  output logic                  push,
  output gtr_pkg::job_t         push_job
);

  logic [gtr_pkg::ScaleW-1:0] glyph_scale;
  logic [gtr_pkg::ColorW-1:0] draw_color;
  logic [gtr_pkg::CoordW-1:0] pen_x;
  logic [gtr_pkg::CoordW-1:0] pen_y;

  logic [gtr_pkg::CoordW-1:0] base_x;
  logic [gtr_pkg::CoordW-1:0] base_y;
  logic [gtr_pkg::ScaleW-1:0] scale;
  logic [gtr_pkg::CoordW-1:0] pen_x_next;

  assign chr.ready = !q_status.full;
  assign cfg.ready = 1'b1;
  assign push      = chr.valid && chr.ready;

  always_comb begin
    scale  = gtr_pkg::effective_scale(glyph_scale);
    base_x = chr.restart ? chr.start_x : pen_x;
    base_y = chr.restart ? chr.start_y : pen_y;
    // advance wraps at 256
    pen_x_next = base_x + gtr_pkg::CoordW'(scale) * gtr_pkg::CoordW'(gtr_pkg::Advance);
    push_job.glyph = gtr_pkg::glyph_select(chr.char_code);
    push_job.pen_x = base_x;
    push_job.pen_y = base_y;
    push_job.scale = scale;
    push_job.color = draw_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale <= gtr_pkg::ScaleW'(1);
      draw_color  <= '1;
      pen_x       <= '0;
      pen_y       <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          gtr_pkg::CFG_GLYPH_SCALE: glyph_scale <= cfg.data[gtr_pkg::ScaleW-1:0];
          gtr_pkg::CFG_DRAW_COLOR:  draw_color  <= cfg.data[gtr_pkg::ColorW-1:0];
          default: ;
        endcase
      end
      if (push) begin
        pen_x <= pen_x_next;
        pen_y <= base_y;
      end
    end
  end

endmodule

FILE: src/gtr_queue.sv
// ----------------------------------------------------------------------------
// gtr_queue
// Short job queue between the character front end and the rectangle back end.
// ----------------------------------------------------------------------------
module gtr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gtr_pkg::job_t          push_job,
  input  logic                   pop,
  output gtr_pkg::job_t          pop_job,
  output gtr_pkg::queue_status_t status
);

  gtr_pkg::job_t              mem [gtr_pkg::QueueDepth];
  logic [gtr_pkg::QPtrW-1:0]  wr_ptr;
  logic [gtr_pkg::QPtrW-1:0]  rd_ptr;
  logic [gtr_pkg::QCntW-1:0]  count;

  assign status.full  = (count == gtr_pkg::QCntW'(gtr_pkg::QueueDepth));
  assign status.empty = (count == '0);
  assign pop_job      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gtr_pkg::QPtrW'(gtr_pkg::QueueDepth - 1)) ? '0
                                                                       : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gtr_pkg::QPtrW'(gtr_pkg::QueueDepth - 1)) ? '0
                                                                       : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/gtr_back.sv
// ----------------------------------------------------------------------------
// gtr_back
// Walks the set dots of one glyph and emits one rectangle per dot.
// ----------------------------------------------------------------------------
module gtr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  gtr_pkg::queue_status_t q_status,
  input  gtr_pkg::job_t          pop_job,
  output logic                   pop,
  gtr_out_if.source              rect
);

  gtr_pkg::back_state_t          state;
  gtr_pkg::back_state_t          state_next;
  gtr_pkg::job_t                 job;
  logic [gtr_pkg::DotN-1:0]      mask;

  logic                          out_valid;
  logic [gtr_pkg::CoordW-1:0]    out_x;
  logic [gtr_pkg::CoordW-1:0]    out_y;
  logic [gtr_pkg::ScaleW-1:0]    out_side;
  logic [gtr_pkg::ColorW-1:0]    out_color;
  logic                          out_empty;
  logic                          out_last;

  logic                          out_free;
  logic                          emit;
  logic                          blank;
  logic [gtr_pkg::DotIdxW-1:0]   pos;
  logic [gtr_pkg::DotN-1:0]      mask_rest;
  logic [gtr_pkg::CoordW-1:0]    dot_x;
  logic [gtr_pkg::CoordW-1:0]    dot_y;

  assign rect.valid      = out_valid;
  assign rect.rect_x     = out_x;
  assign rect.rect_y     = out_y;
  assign rect.rect_side  = out_side;
  assign rect.rect_color = out_color;
  assign rect.empty_res  = out_empty;
  assign rect.last       = out_last;

  assign out_free = !out_valid || rect.ready;

  // lowest remaining dot, column-major order
  always_comb begin
    pos = '0;
    for (int i = gtr_pkg::DotN - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pos = gtr_pkg::DotIdxW'(i);
      end
    end
  end

  always_comb begin
    blank     = (mask == '0);
    mask_rest = mask & ~(gtr_pkg::DotN'(1) << pos);
    dot_x = job.pen_x + gtr_pkg::CoordW'(gtr_pkg::dot_col(pos)) * gtr_pkg::CoordW'(job.scale);
    dot_y = job.pen_y + gtr_pkg::CoordW'(gtr_pkg::dot_row(pos)) * gtr_pkg::CoordW'(job.scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    case (state)
      gtr_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = gtr_pkg::BK_RUN;
        end
      end
      gtr_pkg::BK_RUN: begin
        if (out_free) begin
          emit = 1'b1;
          // a blank glyph also ends here after its single beat
          if (mask_rest == '0) begin
            state_next = gtr_pkg::BK_IDLE;
          end
        end
      end
      default: state_next = gtr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job  <= pop_job;
      mask <= gtr_pkg::font_bits(pop_job.glyph);
    end else if (emit) begin
      mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rect.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= blank ? '0 : dot_x;
      out_y     <= blank ? '0 : dot_y;
      out_side  <= blank ? '0 : job.scale;
      out_color <= blank ? '0 : job.color;
      out_empty <= blank;
      out_last  <= (mask_rest == '0);
    end
  end

endmodule

FILE: src/gtr_checker.sv
// ----------------------------------------------------------------------------
// gtr_checker
// Port-level checks on the rectangle output of the renderer core.
// ----------------------------------------------------------------------------
module gtr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rect_valid,
  input logic                        rect_ready,
  input logic [gtr_pkg::CoordW-1:0]  rect_x,
  input logic [gtr_pkg::CoordW-1:0]  rect_y,
  input logic [gtr_pkg::ScaleW-1:0]  rect_side,
  input logic [gtr_pkg::ColorW-1:0]  rect_color,
  input logic                        empty_res,
  input logic                        last
);

  // output register is emptied by reset
  a_reset_empty : assert property (@(posedge clk) rst |=> !rect_valid)
    else $error("rect valid after reset");

  // a blank glyph is always one beat
  a_blank_last : assert property (@(posedge clk) disable iff (rst)
    rect_valid && empty_res |-> last)
    else $error("empty beat without last");

  a_blank_zero : assert property (@(posedge clk) disable iff (rst)
    rect_valid && empty_res |-> rect_x == '0 && rect_y == '0 && rect_side == '0 &&
                                rect_color == '0)
    else $error("empty beat with non-zero fields");

  a_side_range : assert property (@(posedge clk) disable iff (rst)
    rect_valid && !empty_res |-> rect_side >= gtr_pkg::ScaleW'(1) &&
                                 rect_side <= gtr_pkg::ScaleW'(gtr_pkg::MaxScale))
    else $error("rectangle side out of range");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    rect_valid && !rect_ready |=> rect_valid && $stable(rect_x) && $stable(rect_y) &&
                                  $stable(last) && $stable(empty_res))
    else $error("stalled beat changed");

endmodule

bind glyph_to_rectangle_renderer_core gtr_checker u_gtr_checker (
  .clk        (clk),
  .rst        (rst),
  .rect_valid (rect.valid),
  .rect_ready (rect.ready),
  .rect_x     (rect.rect_x),
  .rect_y     (rect.rect_y),
  .rect_side  (rect.rect_side),
  .rect_color (rect.rect_color),
  .empty_res  (rect.empty_res),
  .last       (rect.last)
);

FILE: tb/sv/tb_glyph_to_rectangle_renderer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_to_rectangle_renderer_core
// Self-checking regression for the glyph to rectangle renderer core. A short
// directed table covers every glyph, blank codes either side of the drawn
// ones, scale limits, colour extremes, pen restarts that wrap and an unmapped
// register write. Random phases with fresh register settings follow. Every
// rectangle beat is checked field by field against a scoreboard filled by an
// in-bench font walker, while the character sender bursts and the rectangle
// receiver stalls to its own pattern.
// ----------------------------------------------------------------------------
module tb_glyph_to_rectangle_renderer_core;
  import gtr_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 160;
  localparam int HOLD_AT_BEAT = 800;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_CHARS  = 35;

  localparam logic [CfgIdxW-1:0] CFG_IDX_UNMAPPED = 4'd9;

  typedef struct packed {
    logic [CoordW-1:0] rect_x;
    logic [CoordW-1:0] rect_y;
    logic [ScaleW-1:0] rect_side;
    logic [ColorW-1:0] rect_color;
    logic              empty_res;
    logic              last;
  } rect_beat_t;

  localparam rect_beat_t BLANK_BEAT = '{8'd0, 8'd0, 5'd0, 16'h0000, 1'b1, 1'b1};

  typedef enum logic {
    ROW_CHAR,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CodeW-1:0]     code;
    logic                 rs;
    logic [CoordW-1:0]    sx;
    logic [CoordW-1:0]    sy;
    logic [CfgIdxW-1:0]   reg_idx;
    logic [CfgDataW-1:0]  reg_data;
    int                   n_typed;
    rect_beat_t           typed [4];
  } stim_row_t;

  logic clk;
  logic rst;

  gtr_in_if  chr_if ();
  gtr_out_if rect_if ();
  gtr_cfg_if cfg_if ();

  glyph_to_rectangle_renderer_core DUT (
    .clk  (clk),
    .rst  (rst),
    .chr  (chr_if),
    .cfg  (cfg_if),
    .rect (rect_if)
  );

  // shadow of the block's registers and pen
  logic [ScaleW-1:0] scale_reg = ScaleW'(1);
  logic [ColorW-1:0] color_reg = 16'hFFFF;
  logic [CoordW-1:0] pen_x     = '0;
  logic [CoordW-1:0] pen_y     = '0;

  rect_beat_t want_rects [$];
  stim_row_t  plan [$];

  int n_chars   = 0;
  int n_writes  = 0;
  int n_beats   = 0;
  int n_errors  = 0;
  int quiet     = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic stim_row_t char_row(logic [CodeW-1:0] code, logic rs,
                                         logic [CoordW-1:0] sx, logic [CoordW-1:0] sy,
                                         bit blank);
    stim_row_t r;
    r.kind     = ROW_CHAR;
    r.code     = code;
    r.rs       = rs;
    r.sx       = sx;
    r.sy       = sy;
    r.reg_idx  = '0;
    r.reg_data = '0;
    r.n_typed  = blank ? 1 : 0;
    r.typed[0] = BLANK_BEAT;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    stim_row_t r;
    r          = char_row('0, 1'b0, '0, '0, 1'b0);
    r.kind     = ROW_REG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // offer one character, and once taken walk its glyph into the scoreboard
  task automatic send_char(input stim_row_t r);
    logic [ScaleW-1:0]                    s;
    logic [GlyphIdxW-1:0]                 g;
    logic [0:GlyphCols-1][GlyphRows-1:0]  cols;
    rect_beat_t                           b;
    rect_beat_t                           dots [$];
    int                                   c;
    int                                   w;
    @(negedge clk);
    chr_if.valid     = 1'b1;
    chr_if.char_code = r.code;
    chr_if.restart   = r.rs;
    chr_if.start_x   = r.sx;
    chr_if.start_y   = r.sy;
    do @(posedge clk); while (chr_if.ready !== 1'b1);

    s = scale_reg;
    if (s == '0) begin
      s = ScaleW'(1);
    end else if (s > ScaleW'(MaxScale)) begin
      s = ScaleW'(MaxScale);
    end
    if (r.code >= CODE_ZERO && r.code <= CODE_NINE) begin
      g = GlyphIdxW'(r.code - CODE_ZERO);
    end else if (r.code == CODE_DOT) begin
      g = GLYPH_DOT;
    end else if (r.code == CODE_VEE) begin
      g = GLYPH_VEE;
    end else begin
      g = GLYPH_BLANK;
    end
    // column 0 first, row 0 is the lsb of each column
    case (g)
      0:         cols = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      1:         cols = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      2:         cols = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      3:         cols = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      4:         cols = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      5:         cols = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      6:         cols = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      7:         cols = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      8:         cols = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      9:         cols = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      GLYPH_DOT: cols = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      GLYPH_VEE: cols = {7'h77, 7'h08, 7'h08, 7'h08, 7'h77};
      default:   cols = '0;
    endcase

    if (r.rs) begin
      pen_x = r.sx;
      pen_y = r.sy;
    end
    for (c = 0; c < GlyphCols; c++) begin
      for (w = 0; w < GlyphRows; w++) begin
        if (cols[c][w]) begin
          b.rect_x     = pen_x + CoordW'(c * s);
          b.rect_y     = pen_y + CoordW'(w * s);
          b.rect_side  = s;
          b.rect_color = color_reg;
          b.empty_res  = 1'b0;
          b.last       = 1'b0;
          dots.push_back(b);
        end
      end
    end
    if (dots.size() == 0) begin
      dots.push_back(BLANK_BEAT);
    end else begin
      b      = dots.pop_back();
      b.last = 1'b1;
      dots.push_back(b);
    end
    pen_x = pen_x + CoordW'(Advance * s);

    if (r.n_typed > 0) begin
      for (c = 0; c < r.n_typed; c++) want_rects.push_back(r.typed[c]);
    end else begin
      foreach (dots[i]) want_rects.push_back(dots[i]);
    end
    n_chars++;
  endtask

  // stop offering and let every outstanding rectangle drain
  task automatic settle();
    @(negedge clk);
    chr_if.valid = 1'b0;
    while (want_rects.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    settle();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    if (idx == CFG_GLYPH_SCALE) begin
      scale_reg = data[ScaleW-1:0];
    end else if (idx == CFG_DRAW_COLOR) begin
      color_reg = data;
    end
    n_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // rectangle scoreboard
  always @(posedge clk) begin
    rect_beat_t got;
    rect_beat_t want;
    if (!rst && rect_if.valid === 1'b1 && rect_if.ready === 1'b1) begin
      got = '{rect_if.rect_x, rect_if.rect_y, rect_if.rect_side, rect_if.rect_color,
              rect_if.empty_res, rect_if.last};
      n_beats++;
      if (want_rects.size() == 0) begin
        $error("rectangle beat with nothing outstanding: x=%0d y=%0d", got.rect_x, got.rect_y);
        n_errors++;
      end else begin
        want = want_rects.pop_front();
        if (got.rect_x !== want.rect_x) begin
          $error("rect_x: expected %0d, got %0d", want.rect_x, got.rect_x);
          n_errors++;
        end
        if (got.rect_y !== want.rect_y) begin
          $error("rect_y: expected %0d, got %0d", want.rect_y, got.rect_y);
          n_errors++;
        end
        if (got.rect_side !== want.rect_side) begin
          $error("rect_side: expected %0d, got %0d", want.rect_side, got.rect_side);
          n_errors++;
        end
        if (got.rect_color !== want.rect_color) begin
          $error("rect_color: expected %h, got %h", want.rect_color, got.rect_color);
          n_errors++;
        end
        if (got.empty_res !== want.empty_res) begin
          $error("empty_res: expected %b, got %b", want.empty_res, got.empty_res);
          n_errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, got.last);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (chr_if.valid === 1'b1 && chr_if.ready === 1'b1) ||
        (rect_if.valid === 1'b1 && rect_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: %0d quiet cycles, %0d rectangles outstanding",
                 quiet, want_rects.size());
        $display("glyph_to_rectangle_renderer_core regression: fail");
        $finish;
      end
    end
  end

  // receiver: spans of always-ready, random stalls and a one-in-three pattern
  initial begin
    int  mode;
    int  span;
    int  tick;
    bit  held;
    rect_if.ready = 1'b0;
    mode = 0;
    span = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!held && n_beats >= HOLD_AT_BEAT && chr_if.valid === 1'b1) begin
        // long hold-off so the job queue fills and chr.ready drops
        held          = 1'b1;
        rect_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(8, 64);
        end
        span--;
        case (mode)
          0:       rect_if.ready = 1'b1;
          1:       rect_if.ready = ($urandom_range(0, 9) < 7);
          default: rect_if.ready = (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    stim_row_t         r;
    int                burst_left;
    int                gap;
    int                n;
    int                ph;
    int                k;
    logic [ScaleW-1:0] s;

    rst              = 1'b1;
    chr_if.valid     = 1'b0;
    chr_if.char_code = '0;
    chr_if.restart   = 1'b0;
    chr_if.start_x   = '0;
    chr_if.start_y   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    burst_left       = 0;

    // after reset: scale 1, white, pen at the origin
    r = char_row(CODE_DOT, 1'b0, 8'd0, 8'd0, 1'b0);
    r.n_typed  = 4;
    r.typed[0] = '{8'd1, 8'd5, 5'd1, 16'hFFFF, 1'b0, 1'b0};
    r.typed[1] = '{8'd1, 8'd6, 5'd1, 16'hFFFF, 1'b0, 1'b0};
    r.typed[2] = '{8'd2, 8'd5, 5'd1, 16'hFFFF, 1'b0, 1'b0};
    r.typed[3] = '{8'd2, 8'd6, 5'd1, 16'hFFFF, 1'b0, 1'b1};
    plan.push_back(r);
    plan.push_back(char_row(8'h00, 1'b0, 8'd0, 8'd0, 1'b1));
    plan.push_back(char_row(8'hFF, 1'b1, 8'hAA, 8'h55, 1'b1));
    plan.push_back(char_row(CODE_ZERO, 1'b0, 8'h55, 8'hAA, 1'b0));
    plan.push_back(char_row(CODE_NINE, 1'b1, 8'd0, 8'h80, 1'b0));
    plan.push_back(char_row(CODE_ZERO - 8'd1, 1'b0, 8'd0, 8'd0, 1'b1));
    plan.push_back(char_row(CODE_NINE + 8'd1, 1'b0, 8'd0, 8'd0, 1'b1));
    plan.push_back(char_row(CODE_VEE + 8'd1, 1'b0, 8'd0, 8'd0, 1'b1));
    plan.push_back(char_row(CODE_VEE - 8'd1, 1'b0, 8'd0, 8'd0, 1'b1));
    // scale zero acts as one, black ink
    plan.push_back(reg_row(CFG_GLYPH_SCALE, 16'hFFE0));
    plan.push_back(reg_row(CFG_DRAW_COLOR, 16'h0000));
    plan.push_back(char_row(CODE_VEE, 1'b1, 8'd250, 8'd250, 1'b0));
    plan.push_back(char_row(CODE_ZERO + 8'd1, 1'b0, 8'd0, 8'd0, 1'b0));
    // scale above the maximum saturates; corner restart wraps both axes
    plan.push_back(reg_row(CFG_GLYPH_SCALE, 16'h001F));
    plan.push_back(reg_row(CFG_DRAW_COLOR, 16'hFFFF));
    plan.push_back(char_row(CODE_ZERO + 8'd8, 1'b1, 8'd255, 8'd255, 1'b0));
    plan.push_back(char_row(CODE_ZERO + 8'd4, 1'b0, 8'd0, 8'd0, 1'b0));
    plan.push_back(char_row(CODE_DOT - 8'd1, 1'b0, 8'd0, 8'd0, 1'b1));
    // unmapped index must leave both registers alone
    plan.push_back(reg_row(CFG_IDX_UNMAPPED, 16'h0003));
    plan.push_back(char_row(CODE_ZERO + 8'd2, 1'b0, 8'd0, 8'd0, 1'b0));
    plan.push_back(reg_row(CFG_GLYPH_SCALE, 16'h0011));
    plan.push_back(char_row(CODE_ZERO + 8'd7, 1'b1, 8'd0, 8'd0, 1'b0));
    plan.push_back(reg_row(CFG_GLYPH_SCALE, 16'h0010));
    plan.push_back(char_row(CODE_ZERO + 8'd3, 1'b0, 8'd0, 8'd0, 1'b0));
    plan.push_back(reg_row(CFG_GLYPH_SCALE, 16'h0002));
    plan.push_back(reg_row(CFG_DRAW_COLOR, 16'hA5A5));
    plan.push_back(char_row(CODE_ZERO + 8'd5, 1'b1, 8'd10, 8'd20, 1'b0));
    plan.push_back(char_row(CODE_ZERO + 8'd6, 1'b0, 8'd0, 8'd0, 1'b0));
    plan.push_back(char_row(CODE_DOT, 1'b0, 8'd0, 8'd0, 1'b0));
    plan.push_back(char_row(CODE_VEE, 1'b0, 8'd0, 8'd0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows go back to back
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_char(plan[i]);
      end
    end
    n = n_chars;

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        1:       s = ScaleW'(MaxScale);
        2:       s = '0;
        3:       s = ScaleW'($urandom_range(MaxScale + 1, 31));
        default: s = ScaleW'($urandom_range(1, 4));
      endcase
      write_reg(CFG_GLYPH_SCALE, {11'($urandom), s});
      write_reg(CFG_DRAW_COLOR, 16'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_UNMAPPED, 16'($urandom));
      end
      burst_left = 0;
      for (k = 0; k < PHASE_CHARS; k++) begin
        if (ph == 2 && k == PHASE_CHARS / 2) begin
          settle();
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            chr_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        gap = $urandom_range(0, 15);
        r = char_row(CODE_ZERO, $urandom_range(0, 4) == 0, 8'($urandom), 8'($urandom), 1'b0);
        if (gap < 10) begin
          r.code = CODE_ZERO + CodeW'(gap);
        end else if (gap == 10) begin
          r.code = CODE_DOT;
        end else if (gap == 11) begin
          r.code = CODE_VEE;
        end else begin
          r.code = CodeW'($urandom_range(0, 255));
        end
        send_char(r);
        burst_left--;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (want_rects.size() != 0) begin
      $error("%0d rectangles never arrived", want_rects.size());
      n_errors++;
    end

    $display("covered %0d characters (%0d from the directed table), %0d register writes",
             n_chars, n, n_writes);
    $display("checked %0d rectangle beats, %0d mismatches", n_beats, n_errors);
    if (n_errors == 0) begin
      $display("glyph_to_rectangle_renderer_core regression: pass");
    end else begin
      $display("glyph_to_rectangle_renderer_core regression: fail");
    end
    $finish;
  end

endmodule
